@@ rtl/core/bdy_pkg.sv @@
package bdy_pkg;

	// pool geometry
	localparam int POOL_UNITS = 64;
	localparam int LEVELS     = 7;
	localparam int NODE_COUNT = 2 * POOL_UNITS - 1;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int ADDR_W     = $clog2(POOL_UNITS);
	localparam int SIZE_W     = ADDR_W + 1;
	localparam int LVL_W      = $clog2(LEVELS);

	// node codes
	typedef enum logic [1:0] {
		ND_ABSENT = 2'd0,
		ND_FREE   = 2'd1,
		ND_USED   = 2'd2,
		ND_SPLIT  = 2'd3
	} node_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DENIED  = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

endpackage

@@ rtl/core/bdy_ram.sv @@
module bdy_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/buddy_allocator.sv @@
// Channel   Handshake          Fields
// request   start / busy       cmd, req_size, free_addr
// result    done (one cycle)   status, block_addr, block_size, denied_count,
//                              live_count, wasted_units
//
// Allocate scans the node memory one node per cycle over the levels down to
// the needed one (up to 127 reads), then splits at two writes per level and
// marks the chosen node used; a free walks down reading one node per level and
// merges upward, with three node writes per level, while the buddy is free.
// After reset a clearing pass writes every node while busy is high.
// Results cannot be stalled; done pulses once per accepted request.
module buddy_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [6:0]                    req_size,
	input  logic [bdy_pkg::ADDR_W-1:0]    free_addr,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [bdy_pkg::ADDR_W-1:0]    block_addr,
	output logic [bdy_pkg::SIZE_W-1:0]    block_size,
	output logic [15:0]                   denied_count,
	output logic [6:0]                    live_count,
	output logic [5:0]                    wasted_units
);

	import bdy_pkg::*;

	typedef enum logic [14:0] {
		S_CLR     = 15'h0001,
		S_IDLE    = 15'h0002,
		S_SCAN    = 15'h0004,
		S_WAIT    = 15'h0008,
		S_PICK    = 15'h0010,
		S_SPL     = 15'h0020,
		S_SPR     = 15'h0040,
		S_USE     = 15'h0080,
		S_FRD     = 15'h0100,
		S_FCHK    = 15'h0200,
		S_FMARK   = 15'h0400,
		S_MRD     = 15'h0800,
		S_MCHK    = 15'h1000,
		S_MW1     = 15'h2000,
		S_MW2     = 15'h4000
	} state_t;

	state_t state_q;

	logic [NODE_W-1:0] clr_q;
	logic [6:0]        req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LVL_W-1:0]  k_q, d_q;
	logic [NODE_W-1:0] cur_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [ADDR_W-1:0] start_q;
	logic [SIZE_W-1:0] size_q;
	logic              mw3_q;

	// scan issue counters and their pipeline copies
	logic [NODE_W-1:0] scan_i_q, scan_last_q;
	logic [LVL_W-1:0]  scan_t_q;
	logic [ADDR_W-1:0] scan_o_q;
	logic              vld_s1;
	logic [NODE_W-1:0] i_s1;
	logic [LVL_W-1:0]  t_s1;
	logic [ADDR_W-1:0] o_s1;

	// search results
	logic              ex_fnd_q, lg_fnd_q;
	logic [NODE_W-1:0] ex_i_q, lg_i_q;
	logic [ADDR_W-1:0] ex_st_q, lg_st_q;
	logic [LVL_W-1:0]  lg_t_q;

	logic [15:0] denied_q;
	logic [6:0]  live_q;
	logic [5:0]  waste_q;

	logic              nd_we;
	logic [NODE_W-1:0] nd_waddr, nd_raddr;
	logic [1:0]        nd_wdata, nd_rdata;
	logic              hr_we;
	logic [6:0]        hr_rdata;

	logic [LVL_W-1:0]  k_c;
	logic [NODE_W-1:0] buddy_c, parent_c;
	logic [SIZE_W-1:0] half_c;
	logic [ADDR_W-1:0] lg_cand_c;

	bdy_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	bdy_ram #(.WIDTH(7), .DEPTH(POOL_UNITS)) u_held_ram (
		.clk   (clk),
		.we    (hr_we),
		.waddr (start_q),
		.wdata (req_q),
		.raddr (addr_q),
		.rdata (hr_rdata)
	);

	// round request up to a power of two
	always_comb begin
		k_c = '0;
		for (int j = 0; j < LEVELS - 1; j++) begin
			if ((7'd1 << j) < req_size) begin
				k_c = LVL_W'(j + 1);
			end
		end
	end

	assign buddy_c   = cur_q[0] ? cur_q + NODE_W'(1) : cur_q - NODE_W'(1);
	assign parent_c  = (cur_q - NODE_W'(1)) >> 1;
	assign half_c    = size_q >> 1;
	assign lg_cand_c = ADDR_W'(o_s1 << (LVL_W'(LEVELS - 1) - t_s1));

	// node memory port selection
	always_comb begin
		nd_we    = 1'b0;
		nd_waddr = cur_q;
		nd_wdata = ND_ABSENT;
		nd_raddr = cur_q;
		hr_we    = 1'b0;
		case (state_q)
			S_CLR: begin
				nd_we    = 1'b1;
				nd_waddr = clr_q;
				nd_wdata = (clr_q == '0) ? ND_FREE : ND_ABSENT;
			end
			S_SCAN:  nd_raddr = scan_i_q;
			S_SPL: begin
				nd_we    = 1'b1;
				nd_wdata = ND_SPLIT;
			end
			S_SPR: begin
				nd_we    = 1'b1;
				nd_waddr = NODE_W'({cur_q, 1'b0} + 2);
				nd_wdata = ND_FREE;
			end
			S_USE: begin
				nd_we    = 1'b1;
				nd_wdata = ND_USED;
				hr_we    = 1'b1;
			end
			S_FMARK: begin
				nd_we    = 1'b1;
				nd_wdata = ND_FREE;
			end
			S_MRD:   nd_raddr = buddy_c;
			S_MW1: begin
				nd_we    = 1'b1;
				nd_wdata = ND_ABSENT;
			end
			S_MW2: begin
				nd_we    = 1'b1;
				nd_waddr = mw3_q ? parent_c : buddy_c;
				nd_wdata = mw3_q ? ND_FREE : ND_ABSENT;
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign denied_count = denied_q;
	assign live_count   = live_q;
	assign wasted_units = waste_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			done     <= 1'b0;
			vld_s1   <= 1'b0;
			denied_q <= '0;
			live_q   <= '0;
			waste_q  <= '0;
			ex_fnd_q <= 1'b0;
			lg_fnd_q <= 1'b0;
			mw3_q    <= 1'b0;
		end else begin
			done   <= 1'b0;
			vld_s1 <= 1'b0;

			// evaluate the node read issued last cycle
			if (vld_s1 && nd_rdata == ND_FREE) begin
				if (t_s1 == d_q && !ex_fnd_q) begin
					ex_fnd_q <= 1'b1;
					ex_i_q   <= i_s1;
					ex_st_q  <= ADDR_W'(o_s1 << k_q);
				end
				if (t_s1 < d_q && (!lg_fnd_q || lg_cand_c < lg_st_q)) begin
					lg_fnd_q <= 1'b1;
					lg_i_q   <= i_s1;
					lg_t_q   <= t_s1;
					lg_st_q  <= lg_cand_c;
				end
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q  <= req_size;
						addr_q <= free_addr;
						if (cmd == CMD_FREE) begin
							cur_q   <= '0;
							lvl_q   <= '0;
							start_q <= '0;
							size_q  <= SIZE_W'(POOL_UNITS);
							state_q <= S_FRD;
						end else if (req_size == '0 || req_size > 7'(POOL_UNITS)) begin
							if (denied_q != 16'hFFFF) denied_q <= denied_q + 16'd1;
							done       <= 1'b1;
							status     <= ST_DENIED;
							block_addr <= '0;
							block_size <= '0;
						end else begin
							k_q         <= k_c;
							d_q         <= LVL_W'(LEVELS - 1) - k_c;
							scan_last_q <= NODE_W'((8'd1 << (LVL_W'(LEVELS - 1) - k_c + 1))
								- 8'd2);
							scan_i_q    <= '0;
							scan_t_q    <= '0;
							scan_o_q    <= '0;
							ex_fnd_q    <= 1'b0;
							lg_fnd_q    <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end
				// issue one node read per cycle in heap order
				S_SCAN: begin
					vld_s1   <= 1'b1;
					i_s1     <= scan_i_q;
					t_s1     <= scan_t_q;
					o_s1     <= scan_o_q;
					scan_i_q <= scan_i_q + NODE_W'(1);
					if (NODE_W'(scan_o_q) == (NODE_W'(1) << scan_t_q) - NODE_W'(1)) begin
						scan_o_q <= '0;
						scan_t_q <= scan_t_q + LVL_W'(1);
					end else begin
						scan_o_q <= scan_o_q + ADDR_W'(1);
					end
					if (scan_i_q == scan_last_q) state_q <= S_WAIT;
				end
				S_WAIT:  state_q <= S_PICK;
				S_PICK: begin
					if (ex_fnd_q) begin
						cur_q   <= ex_i_q;
						start_q <= ex_st_q;
						state_q <= S_USE;
					end else if (lg_fnd_q) begin
						cur_q   <= lg_i_q;
						lvl_q   <= lg_t_q;
						start_q <= lg_st_q;
						state_q <= S_SPL;
					end else begin
						if (denied_q != 16'hFFFF) denied_q <= denied_q + 16'd1;
						done       <= 1'b1;
						status     <= ST_DENIED;
						block_addr <= '0;
						block_size <= '0;
						state_q    <= S_IDLE;
					end
				end
				S_SPL:   state_q <= S_SPR;
				// descend into the lower half
				S_SPR: begin
					cur_q <= NODE_W'({cur_q, 1'b1});
					lvl_q <= lvl_q + LVL_W'(1);
					state_q <= (lvl_q + LVL_W'(1) == d_q) ? S_USE : S_SPL;
				end
				S_USE: begin
					live_q     <= live_q + 7'd1;
					waste_q    <= waste_q + 6'((7'd1 << k_q) - req_q);
					done       <= 1'b1;
					status     <= ST_OK;
					block_addr <= start_q;
					block_size <= SIZE_W'(1) << k_q;
					state_q    <= S_IDLE;
				end
				S_FRD:   state_q <= S_FCHK;
				S_FCHK: begin
					if (nd_rdata == ND_USED && start_q == addr_q) begin
						state_q <= S_FMARK;
					end else if (nd_rdata != ND_SPLIT || lvl_q == LVL_W'(LEVELS - 1)) begin
						done       <= 1'b1;
						status     <= ST_BADFREE;
						block_addr <= '0;
						block_size <= '0;
						state_q    <= S_IDLE;
					end else begin
						size_q <= half_c;
						lvl_q  <= lvl_q + LVL_W'(1);
						if ({1'b0, addr_q} < {1'b0, start_q} + half_c) begin
							cur_q <= NODE_W'({cur_q, 1'b1});
						end else begin
							cur_q   <= NODE_W'({cur_q, 1'b0} + 2);
							start_q <= start_q + ADDR_W'(half_c);
						end
						state_q <= S_FRD;
					end
				end
				S_FMARK: begin
					live_q  <= live_q - 7'd1;
					waste_q <= waste_q - 6'(size_q - SIZE_W'(hr_rdata));
					state_q <= S_MRD;
				end
				// merge with the buddy while it is free
				S_MRD: begin
					if (cur_q == '0) begin
						done       <= 1'b1;
						status     <= ST_OK;
						block_addr <= addr_q;
						block_size <= size_q;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_MCHK;
					end
				end
				S_MCHK: begin
					if (nd_rdata == ND_FREE) begin
						state_q <= S_MW1;
					end else begin
						done       <= 1'b1;
						status     <= ST_OK;
						block_addr <= addr_q;
						block_size <= size_q;
						state_q    <= S_IDLE;
					end
				end
				S_MW1: begin
					mw3_q   <= 1'b0;
					state_q <= S_MW2;
				end
				S_MW2: begin
					if (mw3_q) begin
						mw3_q   <= 1'b0;
						cur_q   <= parent_c;
						state_q <= S_MRD;
					end else begin
						mw3_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ tb/buddy_allocator_tb.sv @@
module buddy_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bdy_pkg::*;

	// allocator state mirror and expected-result queue
	class alloc_scoreboard;
		node_t       nodes[NODE_COUNT];
		logic [6:0]  held_req[POOL_UNITS];
		logic [15:0] denied;
		logic [6:0]  live;
		logic [5:0]  waste;
		logic [43:0] pending[$];
		int          errors;
		// last allocation outcome, used to pick later frees
		int          last_addr;

		function void clear();
			foreach (nodes[i]) nodes[i] = ND_ABSENT;
			foreach (held_req[i]) held_req[i] = '0;
			nodes[0] = ND_FREE;
			denied = '0;
			live = '0;
			waste = '0;
			errors = 0;
			last_addr = -1;
		endfunction

		function void push_result(status_t st, int addr, int size);
			pending.push_back({st, 6'(addr), 7'(size), denied, live, waste});
		endfunction

		function void deny();
			if (denied != 16'hFFFF) denied++;
			push_result(ST_DENIED, 0, 0);
		endfunction

		function void do_alloc(int req);
			int k, d, best, best_d, best_start, idx, sz;
			bit found;
			k = 0;
			found = 0;
			best = 0;
			best_d = 0;
			best_start = 0;
			if (req == 0 || req > POOL_UNITS) begin
				deny();
				return;
			end
			while ((1 << k) < req) k++;
			d = LEVELS - 1 - k;
			// exact size first, lowest address
			for (int o = 0; o < (1 << d) && !found; o++) begin
				idx = (1 << d) - 1 + o;
				if (nodes[idx] == ND_FREE) begin
					best = idx;
					best_d = d;
					best_start = o << k;
					found = 1;
				end
			end
			// otherwise split the lowest-address larger block
			if (!found) begin
				for (int t = 0; t < d; t++) begin
					sz = POOL_UNITS >> t;
					for (int o = 0; o < (1 << t); o++) begin
						idx = (1 << t) - 1 + o;
						if (nodes[idx] == ND_FREE && (!found || o * sz < best_start)) begin
							best = idx;
							best_d = t;
							best_start = o * sz;
							found = 1;
						end
					end
				end
				if (!found) begin
					deny();
					return;
				end
				while (best_d < d) begin
					nodes[best] = ND_SPLIT;
					nodes[2 * best + 1] = ND_FREE;
					nodes[2 * best + 2] = ND_FREE;
					best = 2 * best + 1;
					best_d++;
				end
			end
			nodes[best] = ND_USED;
			held_req[best_start] = 7'(req);
			live = live + 7'd1;
			waste = waste + 6'((1 << k) - req);
			last_addr = best_start;
			push_result(ST_OK, best_start, 1 << k);
		endfunction

		function void do_free(int addr);
			int idx, lvl, base, size, buddy, parent;
			idx = 0;
			lvl = 0;
			base = 0;
			size = POOL_UNITS;
			forever begin
				if (nodes[idx] == ND_USED && base == addr) break;
				if (nodes[idx] != ND_SPLIT || lvl + 1 >= LEVELS) begin
					push_result(ST_BADFREE, 0, 0);
					return;
				end
				size = size >> 1;
				if (addr < base + size) idx = 2 * idx + 1;
				else begin
					idx = 2 * idx + 2;
					base += size;
				end
				lvl++;
			end
			nodes[idx] = ND_FREE;
			live = live - 7'd1;
			waste = waste - 6'(size - held_req[addr]);
			// merge upward while the buddy is free
			while (idx != 0) begin
				buddy = (idx & 1) ? idx + 1 : idx - 1;
				parent = (idx - 1) / 2;
				if (nodes[buddy] != ND_FREE) break;
				nodes[idx] = ND_ABSENT;
				nodes[buddy] = ND_ABSENT;
				nodes[parent] = ND_FREE;
				idx = parent;
			end
			push_result(ST_OK, addr, size);
		endfunction

		function void note_request(logic c, logic [6:0] rs, logic [5:0] fa);
			if (c == CMD_ALLOC) do_alloc(rs);
			else do_free(fa);
		endfunction

		function void check_result(logic [1:0] st, logic [5:0] ba, logic [6:0] bs,
				logic [15:0] dc, logic [6:0] lc, logic [5:0] wu);
			logic [43:0] exp_r;
			logic [43:0] got;
			got = {st, ba, bs, dc, lc, wu};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (exp_r[43:42] != st)
				$display("%0t: status exp %0d got %0d", $time, exp_r[43:42], st);
			if (exp_r[41:36] != ba)
				$display("%0t: block_addr exp %0d got %0d", $time, exp_r[41:36], ba);
			if (exp_r[35:29] != bs)
				$display("%0t: block_size exp %0d got %0d", $time, exp_r[35:29], bs);
			if (exp_r[28:13] != dc)
				$display("%0t: denied_count exp %0d got %0d", $time, exp_r[28:13], dc);
			if (exp_r[12:6] != lc)
				$display("%0t: live_count exp %0d got %0d", $time, exp_r[12:6], lc);
			if (exp_r[5:0] != wu)
				$display("%0t: wasted_units exp %0d got %0d", $time, exp_r[5:0], wu);
			if (exp_r !== got) errors++;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [6:0]          req_size;
	logic [ADDR_W-1:0]   free_addr;
	logic                done;
	logic [1:0]          status;
	logic [ADDR_W-1:0]   block_addr;
	logic [SIZE_W-1:0]   block_size;
	logic [15:0]         denied_count;
	logic [6:0]          live_count;
	logic [5:0]          wasted_units;

	alloc_scoreboard sb;
	int idle_pct;
	int stall_cycles;
	bit timed_out;
	int live_addrs[$];

	buddy_allocator dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
	end

	// compare each result strobe
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, block_addr, block_size, denied_count, live_count,
				wasted_units);
	end

	// send one request, with random idle cycles before it
	task automatic send_req(logic c, logic [6:0] rs, logic [5:0] fa);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		req_size <= rs;
		free_addr <= fa;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(c, rs, fa);
		if (c == CMD_ALLOC && sb.pending[$][43:42] == ST_OK)
			live_addrs.push_back(sb.last_addr);
		if (c == CMD_FREE && sb.pending[$][43:42] == ST_OK)
			foreach (live_addrs[i])
				if (live_addrs[i] == fa) begin
					live_addrs.delete(i);
					break;
				end
	endtask

	task automatic alloc(int rs);
		send_req(CMD_ALLOC, 7'(rs), 6'($urandom));
	endtask

	task automatic release_at(int fa);
		send_req(CMD_FREE, 7'($urandom), 6'(fa));
	endtask

	// one random request, mostly well-formed
	task automatic random_req();
		int r, j;
		r = $urandom_range(99);
		if (r < 45) begin
			if ($urandom_range(9) < 7) alloc($urandom_range(1, 12));
			else alloc($urandom_range(0, 127));
		end else if (r < 90 && live_addrs.size() > 0) begin
			j = $urandom_range(live_addrs.size() - 1);
			release_at(live_addrs[j]);
		end else begin
			release_at($urandom_range(63));
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ALLOC;
		req_size = '0;
		free_addr = '0;
		stall_cycles = 0;
		idle_pct = 0;
		timed_out = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				// directed: extremes and special cases
				alloc(0);
				alloc(65);
				alloc(127);
				release_at(0);
				alloc(64);
				alloc(1);
				release_at(63);
				release_at(0);
				alloc(1);
				alloc(1);
				alloc(3);
				alloc(5);
				alloc(32);
				release_at(1);
				release_at(2);
				release_at(5);
				release_at(4);
				release_at(0);
				release_at(0);
				release_at(8);
				release_at(32);
				release_at(32);
				// random phases with different sender idling
				idle_pct = 36;
				repeat (330) random_req();
				idle_pct = 54;
				repeat (330) random_req();
				idle_pct = 0;
				repeat (330) random_req();
				start <= 1'b0;
				while (sb.pending.size() != 0) @(posedge clk);
				repeat (60) @(posedge clk);
			end
			begin
				wait (stall_cycles >= 2000);
				timed_out = 1;
			end
		join_any
		if (timed_out) begin
			$display("buddy_allocator_tb: done, errors");
			$finish;
		end else begin
			if (sb.errors == 0 && sb.pending.size() == 0)
				$display("buddy_allocator_tb: done, clean");
			else
				$display("buddy_allocator_tb: done, errors");
			$finish;
		end
	end
endmodule
